// ===== hw/rtl/pfw_pkg.sv =====
// pfw_pkg: shared types, field layout and a helper function for the pattern fill line writer
package pfw_pkg;

	// input item field widths
	localparam int PatternW = 64;
	localparam int AddrW    = 48;
	localparam int CountW   = 12;

	// result item field widths
	localparam int LineAddrW = 42;
	localparam int EnableW   = 64;
	localparam int WordW     = 64;

	// line geometry
	localparam int LineBytes  = 64;
	localparam int OffW       = 6;
	localparam int GroupOffW  = 3;
	localparam int EndRelW    = CountW + 1;

	// packed stream widths, rounded up to whole bytes
	localparam int InDataW  = 128;
	localparam int OutDataW = 176;

	// tdata bit positions, input side
	localparam int InPatLo   = 0;
	localparam int InAddrLo  = InPatLo + PatternW;
	localparam int InCountLo = InAddrLo + AddrW;

	// tdata bit positions, output side
	localparam int OutLineLo = 0;
	localparam int OutEnLo   = OutLineLo + LineAddrW;
	localparam int OutWordLo = OutEnLo + EnableW;
	localparam int OutUsedW  = OutWordLo + WordW;

	// status codes
	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_NULL_PTR = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic advance;
	} pfw_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last;
	} pfw_sts_t;

	// rotate a 64-bit word left by a number of whole bytes
	function automatic logic [WordW-1:0] rot_bytes_left(
		input logic [WordW-1:0]     w,
		input logic [GroupOffW-1:0] nbytes
	);
		logic [2*WordW-1:0] dbl;
		logic [OffW:0]      sh;
		sh  = {1'b0, nbytes, 3'b000};
		dbl = {w, w} << sh;
		return dbl[2*WordW-1:WordW];
	endfunction

endpackage

// ===== hw/rtl/pfw_dp.sv =====
// pfw_dp: command registers, line counter and byte-enable mask generation
module pfw_dp #(
	parameter int MAX_FILL_BYTES = 2048
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pfw_pkg::pfw_cmd_t                  cmd,
	output pfw_pkg::pfw_sts_t                  sts,
	input  logic [pfw_pkg::InDataW-1:0]        in_data,
	output logic [pfw_pkg::LineAddrW-1:0]      line_address,
	output logic [pfw_pkg::EnableW-1:0]        byte_enable,
	output logic [pfw_pkg::WordW-1:0]          line_word,
	output logic                               status
);

	// highest line index after the first one, plus one for zero
	localparam int MaxLeft = (MAX_FILL_BYTES + pfw_pkg::LineBytes - 2) / pfw_pkg::LineBytes;
	localparam int LeftW   = (MaxLeft < 1) ? 1 : $clog2(MaxLeft + 1);
	localparam logic [pfw_pkg::CountW-1:0] MaxCount = pfw_pkg::CountW'(MAX_FILL_BYTES);

	logic [pfw_pkg::PatternW-1:0]  in_pattern;
	logic [pfw_pkg::AddrW-1:0]     in_start;
	logic [pfw_pkg::CountW-1:0]    in_count;
	logic [pfw_pkg::CountW-1:0]    count_sat;
	logic [pfw_pkg::EndRelW-1:0]   end_rel;
	logic                          in_null;
	logic                          in_zero;

	logic [pfw_pkg::WordW-1:0]     word_q;
	logic [pfw_pkg::LineAddrW-1:0] line_q;
	logic [pfw_pkg::OffW-1:0]      lo_q;
	logic [pfw_pkg::OffW-1:0]      hi_q;
	logic [LeftW-1:0]              left_q;
	logic                          first_q;
	logic                          empty_q;
	logic                          status_q;

	logic                          last;
	logic [pfw_pkg::OffW-1:0]      lo_cur;
	logic [pfw_pkg::OffW-1:0]      hi_cur;

	assign in_pattern = in_data[pfw_pkg::InPatLo +: pfw_pkg::PatternW];
	assign in_start   = in_data[pfw_pkg::InAddrLo +: pfw_pkg::AddrW];
	assign in_count   = in_data[pfw_pkg::InCountLo +: pfw_pkg::CountW];

	assign in_null   = (in_start == '0);
	assign in_zero   = (in_count == '0);
	assign count_sat = (in_count > MaxCount) ? MaxCount : in_count;
	assign end_rel   = pfw_pkg::EndRelW'(in_start[pfw_pkg::OffW-1:0])
	                 + pfw_pkg::EndRelW'(count_sat) - pfw_pkg::EndRelW'(1);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			word_q <= in_null ? '0
			        : pfw_pkg::rot_bytes_left(in_pattern, in_start[pfw_pkg::GroupOffW-1:0]);
			line_q <= in_null ? '0 : in_start[pfw_pkg::AddrW-1:pfw_pkg::OffW];
			lo_q   <= in_start[pfw_pkg::OffW-1:0];
			hi_q   <= end_rel[pfw_pkg::OffW-1:0];
		end else if (cmd.advance) begin
			line_q <= line_q + pfw_pkg::LineAddrW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			first_q  <= 1'b0;
			empty_q  <= 1'b0;
			status_q <= pfw_pkg::STATUS_OK;
		end else if (cmd.load) begin
			left_q   <= (in_null || in_zero) ? '0
			          : LeftW'(end_rel[pfw_pkg::EndRelW-1:pfw_pkg::OffW]);
			first_q  <= 1'b1;
			empty_q  <= in_null || in_zero;
			status_q <= in_null ? pfw_pkg::STATUS_NULL_PTR : pfw_pkg::STATUS_OK;
		end else if (cmd.advance) begin
			left_q  <= left_q - LeftW'(1);
			first_q <= 1'b0;
		end
	end

	assign last   = (left_q == '0);
	assign lo_cur = first_q ? lo_q : '0;
	assign hi_cur = last ? hi_q : '1;

	always_comb begin
		for (int k = 0; k < pfw_pkg::EnableW; k++) begin
			byte_enable[k] = !empty_q
			              && (pfw_pkg::OffW'(k) >= lo_cur)
			              && (pfw_pkg::OffW'(k) <= hi_cur);
		end
	end

	assign line_address = line_q;
	assign line_word    = word_q;
	assign status       = status_q;
	assign sts.last     = last;

	a_adv_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance |-> !last)
		else $error("advance past the final line");

	a_adv_line_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance && !cmd.load |=> line_q == $past(line_q) + pfw_pkg::LineAddrW'(1))
		else $error("line address did not step by one");

	a_empty_single: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q |-> last && (byte_enable == '0))
		else $error("empty or error command must give one masked-off line");

endmodule

// ===== hw/rtl/pfw_ctrl.sv =====
// pfw_ctrl: handshake controller that sequences the line writes of one command
module pfw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output pfw_pkg::pfw_cmd_t cmd,
	input  pfw_pkg::pfw_sts_t sts
);

	pfw_pkg::state_t state_q;
	pfw_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		cmd.load    = 1'b0;
		cmd.advance = 1'b0;
		unique case (state_q)
			pfw_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = pfw_pkg::ST_RUN;
				end
			end
			pfw_pkg::ST_RUN: begin
				out_valid = 1'b1;
				// the next command may load as the final line leaves
				in_ready  = out_ready && sts.last;
				if (out_ready) begin
					if (!sts.last) begin
						cmd.advance = 1'b1;
					end else if (in_valid) begin
						cmd.load = 1'b1;
					end else begin
						state_d = pfw_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = pfw_pkg::ST_IDLE;
			end
		endcase
	end

	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && cmd.advance))
		else $error("load and advance in the same cycle");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && sts.last && !in_valid |=> !out_valid)
		else $error("output still valid after the final line");

	a_load_gives_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> out_valid)
		else $error("loaded command produced no line");

endmodule

// ===== hw/rtl/pattern_fill_line_writer.sv =====
// pattern_fill_line_writer: top level that turns a fill command into 64-byte line writes
//
//  channel   dir  handshake                    content
//  s_axis    in   s_axis_tvalid/s_axis_tready  one fill command item
//  m_axis    out  m_axis_tvalid/m_axis_tready  one line write item, tlast on the final line
//
// a command of n lines gives n line items, in line order; n is
// (start mod 64 + count - 1) / 64 + 1, at most 33, or one for a zero count or null start.
// the line counter in the datapath paces the output at one line per cycle while m_axis_tready is high.
// the next command is taken in the same cycle the final line item is accepted.
// a stall on m_axis holds the current line item; nothing is dropped.
// reset (arst_n low) returns the controller to idle and discards any command in flight.
module pattern_fill_line_writer #(
	parameter int MAX_FILL_BYTES = 2048
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// command input
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// fill_pattern[63:0], start_address[111:64], byte_count[123:112], zero pad
	input  logic [pfw_pkg::InDataW-1:0]     s_axis_tdata,
	// line write output
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// line_address[41:0], byte_enable[105:42], line_word[169:106], zero pad
	output logic [pfw_pkg::OutDataW-1:0]    m_axis_tdata,
	// status[0]: 0 ok, 1 null start address
	output logic                            m_axis_tuser,
	output logic                            m_axis_tlast
);

	pfw_pkg::pfw_cmd_t             cmd;
	pfw_pkg::pfw_sts_t             sts;
	logic [pfw_pkg::LineAddrW-1:0] line_address;
	logic [pfw_pkg::EnableW-1:0]   byte_enable;
	logic [pfw_pkg::WordW-1:0]     line_word;
	logic                          status;

	// controller: owns the handshakes, issues load and advance
	pfw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// datapath: holds the command, walks the lines, forms the masks
	pfw_dp #(
		.MAX_FILL_BYTES (MAX_FILL_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_data      (s_axis_tdata),
		.line_address (line_address),
		.byte_enable  (byte_enable),
		.line_word    (line_word),
		.status       (status)
	);

	// pack the line item, pad bits tied low
	assign m_axis_tdata = {
		(pfw_pkg::OutDataW - pfw_pkg::OutUsedW)'(0),
		line_word,
		byte_enable,
		line_address
	};
	assign m_axis_tuser = status;
	assign m_axis_tlast = sts.last;

endmodule

// ===== dv/tb.sv =====
// tb: self-checking testbench for the pattern fill line writer
`timescale 1ns / 1ps

module tb;

	localparam int FillMax    = 2048;
	localparam int CycleLimit = 300000;
	localparam int IdlePct    = 30;
	localparam int PrintCap   = 40;

	// one line write as seen on m_axis
	typedef struct packed {
		logic [pfw_pkg::LineAddrW-1:0] line_addr;
		logic [pfw_pkg::EnableW-1:0]   byte_en;
		logic [pfw_pkg::WordW-1:0]     word;
		logic                          status;
		logic                          last;
	} line_write_t;

	// keeps the line writes each command should cause, oldest first
	class fill_scoreboard;
		line_write_t pending_lines[$];
		int errors;
		int n_commands;
		int n_lines;
		int n_null;
		int n_empty;
		int n_clipped;
		int most_lines;

		function new();
			errors     = 0;
			n_commands = 0;
			n_lines    = 0;
			n_null     = 0;
			n_empty    = 0;
			n_clipped  = 0;
			most_lines = 0;
		endfunction

		task report(string what);
			errors++;
			if (errors <= PrintCap) $display("mismatch: %s", what);
		endtask

		// work out the line writes of one accepted fill command
		function void note_command(logic [pfw_pkg::PatternW-1:0] pattern,
			logic [pfw_pkg::AddrW-1:0] start, logic [pfw_pkg::CountW-1:0] count);
			line_write_t lw;
			logic [pfw_pkg::WordW-1:0] rot;
			int unsigned n, off, end_rel, nlines, lo, hi;
			n_commands++;
			if (start == '0) begin
				// null start wins over every count
				lw = '{line_addr: '0, byte_en: '0, word: '0,
					status: pfw_pkg::STATUS_NULL_PTR, last: 1'b1};
				pending_lines.push_back(lw);
				n_null++;
				return;
			end
			// pattern byte k lands at byte (k + start mod 8) of each group
			for (int k = 0; k < 8; k++)
				rot[8*((k + start[2:0]) % 8) +: 8] = pattern[8*k +: 8];
			if (count == '0) begin
				lw = '{line_addr: start[pfw_pkg::AddrW-1:pfw_pkg::OffW], byte_en: '0,
					word: rot, status: pfw_pkg::STATUS_OK, last: 1'b1};
				pending_lines.push_back(lw);
				n_empty++;
				return;
			end
			n = 32'(count);
			if (n > FillMax) begin
				n = FillMax;
				n_clipped++;
			end
			off     = 32'(start[pfw_pkg::OffW-1:0]);
			end_rel = off + n - 1;
			nlines  = end_rel / pfw_pkg::LineBytes + 1;
			if (nlines > most_lines) most_lines = nlines;
			for (int unsigned i = 0; i < nlines; i++) begin
				lo = (i == 0) ? off : 0;
				hi = (i == nlines - 1) ? end_rel % pfw_pkg::LineBytes
				                       : pfw_pkg::LineBytes - 1;
				lw.byte_en = '0;
				for (int unsigned b = lo; b <= hi; b++) lw.byte_en[b] = 1'b1;
				// line index wraps at the top of the address space
				lw.line_addr = start[pfw_pkg::AddrW-1:pfw_pkg::OffW]
				             + pfw_pkg::LineAddrW'(i);
				lw.word      = rot;
				lw.status    = pfw_pkg::STATUS_OK;
				lw.last      = (i == nlines - 1);
				pending_lines.push_back(lw);
			end
		endfunction

		task check_line(line_write_t got);
			line_write_t want;
			if (pending_lines.size() == 0) begin
				report($sformatf("line write %h with nothing pending", got.line_addr));
				return;
			end
			want = pending_lines.pop_front();
			n_lines++;
			if (got.line_addr !== want.line_addr)
				report($sformatf("line_address %h, want %h", got.line_addr, want.line_addr));
			if (got.byte_en !== want.byte_en)
				report($sformatf("byte_enable %h, want %h (line %h)", got.byte_en,
					want.byte_en, want.line_addr));
			if (got.word !== want.word)
				report($sformatf("line_word %h, want %h (line %h)", got.word, want.word,
					want.line_addr));
			if (got.status !== want.status)
				report($sformatf("status %b, want %b (line %h)", got.status, want.status,
					want.line_addr));
			if (got.last !== want.last)
				report($sformatf("last %b, want %b (line %h)", got.last, want.last,
					want.line_addr));
		endtask
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         s_axis_tvalid;
	logic                         s_axis_tready;
	logic [pfw_pkg::InDataW-1:0]  s_axis_tdata;
	logic                         m_axis_tvalid;
	logic                         m_axis_tready;
	logic [pfw_pkg::OutDataW-1:0] m_axis_tdata;
	logic                         m_axis_tuser;
	logic                         m_axis_tlast;

	fill_scoreboard board;
	bit  tx_gaps;
	bit  rx_gaps;
	int  rx_hold_left;
	int  cycles;

	pattern_fill_line_writer #(
		.MAX_FILL_BYTES(FillMax)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles, %0d line writes still pending", cycles,
				board.pending_lines.size());
			$display("FAILURE");
			$finish;
		end
	end

	// offer one fill command and wait until it is taken
	task automatic send_fill(logic [pfw_pkg::PatternW-1:0] pat,
		logic [pfw_pkg::AddrW-1:0] addr, logic [pfw_pkg::CountW-1:0] cnt);
		if (tx_gaps) begin
			while ($urandom_range(99) < IdlePct) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(pfw_pkg::InDataW - pfw_pkg::PatternW - pfw_pkg::AddrW
			- pfw_pkg::CountW){1'b0}}, cnt, addr, pat};
		do @(posedge clk); while (!s_axis_tready);
		board.note_command(pat, addr, cnt);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (board.pending_lines.size() != 0) @(posedge clk);
	endtask

	// line write sink: check, then pick next tready
	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready)
				board.check_line('{
					line_addr: m_axis_tdata[pfw_pkg::OutLineLo +: pfw_pkg::LineAddrW],
					byte_en: m_axis_tdata[pfw_pkg::OutEnLo +: pfw_pkg::EnableW],
					word: m_axis_tdata[pfw_pkg::OutWordLo +: pfw_pkg::WordW],
					status: m_axis_tuser, last: m_axis_tlast});
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				m_axis_tready <= 1'b0;
			end else if (rx_gaps && $urandom_range(99) < IdlePct) begin
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		logic [pfw_pkg::PatternW-1:0] pat;
		logic [pfw_pkg::AddrW-1:0]    addr;
		logic [pfw_pkg::CountW-1:0]   cnt;
		int                           r;
		board         = new();
		tx_gaps       = 1'b0;
		rx_gaps       = 1'b0;
		rx_hold_left  = 0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: null start, empty fill, clipping, head and tail masks, wrap
		send_fill(64'hFFFF_FFFF_FFFF_FFFF, 48'h0, 12'd0);
		send_fill(64'h0123_4567_89AB_CDEF, 48'h0, 12'd2048);
		send_fill(64'h0123_4567_89AB_CDEF, 48'h0000_0000_1235, 12'd0);
		send_fill(64'h0123_4567_89AB_CDEF, 48'h0000_0000_0001, 12'd1);
		send_fill(64'h0000_0000_0000_0000, 48'h0000_0000_0040, 12'd64);
		send_fill(64'hFFFF_FFFF_FFFF_FFFF, 48'h0000_0000_0040, 12'd65);
		send_fill(64'h1122_3344_5566_7788, 48'h0000_0000_0080, 12'd2048);
		send_fill(64'h1122_3344_5566_7788, 48'h0000_0000_00BF, 12'd2048);
		send_fill(64'hA5A5_5A5A_0F0F_F0F0, 48'h0000_0001_0003, 12'd4095);
		send_fill(64'hA5A5_5A5A_0F0F_F0F0, 48'h0000_0001_0007, 12'd2049);
		send_fill(64'hDEAD_BEEF_CAFE_F00D, 48'hFFFF_FFFF_FFFF, 12'd100);
		send_fill(64'hDEAD_BEEF_CAFE_F00D, 48'hFFFF_FFFF_FFC0, 12'd2048);
		send_fill(64'h8000_0000_0000_0001, 48'h0000_0000_0101, 12'd63);
		// tail ending exactly on a line boundary
		send_fill(64'h0123_4567_89AB_CDEF, 48'h0000_0000_0210, 12'd48);
		for (int k = 1; k < 8; k++)
			send_fill(64'h0807_0605_0403_0201, 48'h0000_0000_1000 + 48'(k), 12'(9 + k));
		wait_drained();

		// receiver holds off while commands keep coming, so the input backs up
		rx_hold_left = 250;
		for (int k = 0; k < 10; k++)
			send_fill({$urandom, $urandom}, 48'h0000_0200_0000 + 48'(k * 37), 12'd300);
		wait_drained();

		for (int n = 0; n < 340; n++) begin
			// a long stretch with no idling on either side
			tx_gaps = !(n >= 120 && n < 170);
			rx_gaps = tx_gaps;
			if (n == 230) wait_drained();
			pat = {$urandom, $urandom};
			r = $urandom_range(99);
			if (r < 5) addr = '0;
			else if (r < 12) addr = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(2100));
			else if (r < 22) addr = pfw_pkg::AddrW'({$urandom, $urandom}) & ~48'h3F;
			else addr = pfw_pkg::AddrW'({$urandom, $urandom});
			if (r >= 12 && r < 22 && addr == '0) addr = 48'h40;
			r = $urandom_range(99);
			if (r < 8) cnt = '0;
			else if (r < 16) cnt = 12'd2048;
			else if (r < 24) cnt = 12'($urandom_range(4095, 2049));
			else if (r < 65) cnt = 12'($urandom_range(70, 1));
			else cnt = 12'($urandom_range(2047, 1));
			send_fill(pat, addr, cnt);
		end
		wait_drained();
		// stray line writes after the last expected one are caught by the sink
		repeat (50) @(posedge clk);

		$display("covered %0d fill commands, %0d line writes checked, up to %0d lines each",
			board.n_commands, board.n_lines, board.most_lines);
		$display("null starts %0d, empty fills %0d, clipped counts %0d, mismatches %0d",
			board.n_null, board.n_empty, board.n_clipped, board.errors);
		if (board.pending_lines.size() != 0)
			board.report($sformatf("%0d line writes never arrived",
				board.pending_lines.size()));
		if (board.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
